// ===== rtl/core/sgmpa_pkg.sv =====
// Shared types and constants of the SGM path cost aggregation block.
// No dependencies; every other file but sgmpa_ram refers to it by scoped names.
`default_nettype none

package sgmpa_pkg;

  // Field widths of the streams and the configuration registers
  localparam int MATCH_COST_W = 14;
  localparam int GRAY_W       = 8;
  localparam int AGG_W        = 15;
  localparam int DISP_IDX_W   = 6;
  localparam int P1_W         = 8;
  localparam int P2_W         = 10;
  localparam int DCOUNT_W     = 7;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_INDEX_W  = 2;

  // P2 divisor is |gray difference| + 1, so one bit wider than gray
  localparam int DIVISOR_W = GRAY_W + 1;

  localparam int MAX_DISPARITIES_DEF = 64;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [P1_W-1:0]     RST_PENALTY_SMALL      = P1_W'(10);
  localparam logic [P2_W-1:0]     RST_PENALTY_LARGE_BASE = P2_W'(150);
  localparam logic [DCOUNT_W-1:0] RST_DISPARITY_COUNT    = DCOUNT_W'(64);

  localparam logic [AGG_W-1:0] COST_MAX = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PENALTY_SMALL      = 2'd0,
    CFG_PENALTY_LARGE_BASE = 2'd1,
    CFG_DISPARITY_COUNT    = 2'd2
  } cfg_index_t;

  // One classified element as it travels from the front to the back
  typedef struct packed {
    logic [MATCH_COST_W-1:0] match_cost;
    logic                    path_start;
    logic                    pixel_last;
    logic [P2_W-1:0]         large_penalty;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sgmpa_ifs.sv =====
// Valid/ready stream interfaces for cost elements and aggregated results.
// Depends on sgmpa_pkg for field widths.
`default_nettype none

interface sgmpa_in_if;
  logic                                valid;
  logic                                ready;
  logic [sgmpa_pkg::MATCH_COST_W-1:0]  match_cost;
  logic [sgmpa_pkg::GRAY_W-1:0]        gray;
  logic                                path_start;

  modport source (output valid, output match_cost, output gray, output path_start,
                  input ready);
  modport sink   (input valid, input match_cost, input gray, input path_start,
                  output ready);
endinterface

interface sgmpa_out_if;
  logic                              valid;
  logic                              ready;
  logic [sgmpa_pkg::AGG_W-1:0]       aggregated_cost;
  logic [sgmpa_pkg::DISP_IDX_W-1:0]  disparity_index;
  logic                              pixel_done;

  modport source (output valid, output aggregated_cost, output disparity_index,
                  output pixel_done, input ready);
  modport sink   (input valid, input aggregated_cost, input disparity_index,
                  input pixel_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sgmpa_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module sgmpa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sgmpa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-pixel P2 penalty.
// Standalone; widths default from sgmpa_pkg.
`default_nettype none

module sgmpa_div #(
  parameter int NUM_W = sgmpa_pkg::P2_W,
  parameter int DEN_W = sgmpa_pkg::DIVISOR_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem, quo[NUM_W-1]};
    trial_sub = trial - {1'b0, den};
    fits      = trial >= {1'b0, den};
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out of the top of quo while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= trial_sub[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sgmpa_queue.sv =====
// Short register FIFO between the front and back parts of the block.
// Depends on sgmpa_pkg for the status struct.
`default_nettype none

module sgmpa_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = sgmpa_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [WIDTH-1:0]     push_data,
  input  wire logic                 pop,
  output logic      [WIDTH-1:0]     head,
  output wire sgmpa_pkg::q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sgmpa_front.sv =====
// Front part: accepts cost elements, tracks the disparity offset, computes P2
// once per pixel through sgmpa_div and pushes classified elements to the queue.
`default_nettype none

module sgmpa_front #(
  parameter int MAX_DISPARITIES = sgmpa_pkg::MAX_DISPARITIES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  sgmpa_in_if.sink                                   cost_in,
  input  wire logic [sgmpa_pkg::P2_W-1:0]            penalty_large_base,
  input  wire logic [$clog2(MAX_DISPARITIES+1)-1:0]  active_count,
  input  wire sgmpa_pkg::q_status_t                  q_status,
  output logic                                       push,
  output logic      [$clog2(MAX_DISPARITIES)-1:0]    push_d,
  output sgmpa_pkg::q_entry_t                        push_entry
);

  localparam int DW = $clog2(MAX_DISPARITIES);
  localparam int NW = $clog2(MAX_DISPARITIES + 1);

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_PUSH   = 3'b100
  } state_t;

  state_t                                  state;
  logic [DW-1:0]                           counter;
  logic [sgmpa_pkg::GRAY_W-1:0]            prev_gray;
  logic [sgmpa_pkg::P2_W-1:0]              large_penalty;
  logic [sgmpa_pkg::MATCH_COST_W-1:0]      hold_cost;
  logic                                    hold_start;
  logic                                    hold_last;

  logic                                    accept;
  logic                                    is_first;
  logic                                    last_now;
  logic [sgmpa_pkg::GRAY_W-1:0]            gray_diff;
  logic [sgmpa_pkg::DIVISOR_W-1:0]         divisor;
  logic                                    div_done;
  logic [sgmpa_pkg::P2_W-1:0]              quotient;

  assign cost_in.ready = (state == ST_ACCEPT) && !q_status.full;
  assign accept        = cost_in.valid && cost_in.ready;
  assign is_first      = counter == '0;
  assign last_now      = (NW'(counter) + NW'(1)) >= active_count;

  always_comb begin
    if (cost_in.gray >= prev_gray) begin
      gray_diff = cost_in.gray - prev_gray;
    end else begin
      gray_diff = prev_gray - cost_in.gray;
    end
    divisor = sgmpa_pkg::DIVISOR_W'(gray_diff) + sgmpa_pkg::DIVISOR_W'(1);
  end

  sgmpa_div #(
    .NUM_W (sgmpa_pkg::P2_W),
    .DEN_W (sgmpa_pkg::DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && is_first),
    .dividend (penalty_large_base),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // The first element of a pixel waits in the hold registers for its P2
  always_comb begin
    if (state == ST_PUSH) begin
      push                     = !q_status.full;
      push_d                   = '0;
      push_entry.match_cost    = hold_cost;
      push_entry.path_start    = hold_start;
      push_entry.pixel_last    = hold_last;
    end else begin
      push                     = accept && !is_first;
      push_d                   = counter;
      push_entry.match_cost    = cost_in.match_cost;
      push_entry.path_start    = cost_in.path_start;
      push_entry.pixel_last    = last_now;
    end
    push_entry.large_penalty = large_penalty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_ACCEPT;
      counter       <= '0;
      prev_gray     <= '0;
      large_penalty <= '0;
    end else begin
      case (state)
        ST_ACCEPT: begin
          if (accept) begin
            counter <= last_now ? '0 : counter + DW'(1);
            if (is_first) begin
              prev_gray <= cost_in.gray;
              state     <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            large_penalty <= quotient;
            state         <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_status.full) begin
            state <= ST_ACCEPT;
          end
        end
        default: begin
          state <= ST_ACCEPT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_first) begin
      hold_cost  <= cost_in.match_cost;
      hold_start <= cost_in.path_start;
      hold_last  <= last_now;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sgmpa_back.sv =====
// Back part: reads the previous pixel's costs, forms the path minimum and the
// aggregated cost, writes it back and registers the result for the output.
// Depends on sgmpa_pkg, sgmpa_ifs and sgmpa_ram.
`default_nettype none

module sgmpa_back #(
  parameter int MAX_DISPARITIES = sgmpa_pkg::MAX_DISPARITIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [sgmpa_pkg::P1_W-1:0]          penalty_small,
  input  wire sgmpa_pkg::q_status_t                q_status,
  input  wire logic [$clog2(MAX_DISPARITIES)-1:0]  head_d,
  input  wire sgmpa_pkg::q_entry_t                 head_entry,
  output logic                                     pop,
  sgmpa_out_if.source                              result_out
);

  localparam int DW = $clog2(MAX_DISPARITIES);
  localparam int CW = sgmpa_pkg::AGG_W;
  localparam int MW = CW + 1;
  localparam int SW = MW + 1;

  // Stage 1: RAM read in flight
  logic                 s1_valid;
  logic [DW-1:0]        s1_d;
  sgmpa_pkg::q_entry_t  s1_entry;
  // Stage 2: minimum term registered
  logic                 s2_valid;
  logic [DW-1:0]        s2_d;
  sgmpa_pkg::q_entry_t  s2_entry;
  logic [MW-1:0]        s2_m;
  // Output register
  logic                 out_valid;
  logic [CW-1:0]        out_cost;
  logic [DW-1:0]        out_d;
  logic                 out_done;

  logic [CW-1:0]        left_hold;
  logic [CW-1:0]        prev_min;
  logic [CW-1:0]        running_min;

  logic [CW-1:0]        rd_cur;
  logic [CW-1:0]        rd_right;
  logic [DW-1:0]        raddr_b;

  logic                 out_free;
  logic                 s2_adv;
  logic                 s1_adv;
  logic                 s1_free;
  logic                 head_ok;

  logic [MW-1:0]        cand_left;
  logic [MW-1:0]        cand_right;
  logic [MW-1:0]        cand_p2;
  logic [MW-1:0]        m;

  logic [SW-1:0]        sum;
  logic [SW-1:0]        pm_ext;
  logic [SW-1:0]        diff;
  logic [CW-1:0]        result;
  logic [CW-1:0]        run_next;

  // A new pixel starts only once the previous one has fully committed
  assign out_free = !out_valid || result_out.ready;
  assign s2_adv   = s2_valid && out_free;
  assign s1_adv   = s1_valid && (!s2_valid || s2_adv);
  assign s1_free  = !s1_valid || s1_adv;
  assign head_ok  = !q_status.empty && ((head_d != '0) || (!s1_valid && !s2_valid));
  assign pop      = head_ok && s1_free;
  assign raddr_b  = head_entry.pixel_last ? head_d : head_d + DW'(1);

  sgmpa_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_DISPARITIES)
  ) u_path_costs (
    .clk     (clk),
    .we      (s2_adv),
    .waddr   (s2_d),
    .wdata   (result),
    .re      (pop),
    .raddr_a (head_d),
    .raddr_b (raddr_b),
    .rdata_a (rd_cur),
    .rdata_b (rd_right)
  );

  always_comb begin
    cand_left  = {1'b0, left_hold} + MW'(penalty_small);
    cand_right = {1'b0, rd_right} + MW'(penalty_small);
    cand_p2    = {1'b0, prev_min} + MW'(s1_entry.large_penalty);
    m          = {1'b0, rd_cur};
    if ((s1_d != '0) && (cand_left < m)) begin
      m = cand_left;
    end
    if (!s1_entry.pixel_last && (cand_right < m)) begin
      m = cand_right;
    end
    if (cand_p2 < m) begin
      m = cand_p2;
    end
  end

  // Path starts pass their cost through; else saturate to 0 below, ceiling above
  always_comb begin
    sum    = SW'(s2_entry.match_cost) + SW'(s2_m);
    pm_ext = SW'(prev_min);
    diff   = sum - pm_ext;
    if (s2_entry.path_start) begin
      result = CW'(s2_entry.match_cost);
    end else if (sum <= pm_ext) begin
      result = '0;
    end else if (diff > SW'(sgmpa_pkg::COST_MAX)) begin
      result = sgmpa_pkg::COST_MAX;
    end else begin
      result = diff[CW-1:0];
    end
    run_next = (result < running_min) ? result : running_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      left_hold   <= '0;
      prev_min    <= sgmpa_pkg::COST_MAX;
      running_min <= sgmpa_pkg::COST_MAX;
    end else begin
      if (s1_free) begin
        s1_valid <= pop;
      end
      if (!s2_valid || s2_adv) begin
        s2_valid <= s1_adv;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
      if (s1_adv) begin
        left_hold <= rd_cur;
      end
      if (s2_adv) begin
        if (s2_entry.pixel_last) begin
          prev_min    <= run_next;
          running_min <= sgmpa_pkg::COST_MAX;
        end else begin
          running_min <= run_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_d     <= head_d;
      s1_entry <= head_entry;
    end
    if (s1_adv) begin
      s2_d     <= s1_d;
      s2_entry <= s1_entry;
      s2_m     <= m;
    end
    if (s2_adv) begin
      out_cost <= result;
      out_d    <= s2_d;
      out_done <= s2_entry.pixel_last;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.aggregated_cost = out_cost;
  assign result_out.disparity_index = sgmpa_pkg::DISP_IDX_W'(out_d);
  assign result_out.pixel_done      = out_done;

endmodule

`default_nettype wire

// ===== rtl/core/sgm_path_cost_aggregation_top.sv =====
// SGM path cost aggregation along one scan path: top level with config registers.
// Depends on sgmpa_pkg, sgmpa_ifs, sgmpa_front, sgmpa_queue and sgmpa_back.
//
// Feed matching costs one disparity per transfer, offsets 0 to N-1 of a pixel
// in order, pixel after pixel along the path; the scan direction is set by the
// feed order alone. Each accepted element yields exactly one result transfer:
// Lr = C + min(L[d], L[d-1]+P1, L[d+1]+P1, prevMin+P2) - prevMin, saturated
// to 0..32767, with the disparity offset and a flag on the pixel's last offset.
// Mark every element of a path's first pixel with path_start; those pass their
// cost through. P2 = penalty_large_base / (|gray - previous gray| + 1) is taken
// once per pixel on offset 0 by a bit-serial divider in the front part, which
// stalls input on that element; the remaining offsets enter at one per cycle
// while the queue has room. The back part works through a three-stage pipeline
// (path cost RAM read, minimum, final sum) behind a 4-entry queue and holds
// offset 0 of each pixel until the previous pixel has committed.
// Path cost memory holds no reset;
// entries are only meaningful after a path_start pixel has written them.
// Write configuration only while no element is in flight.
`default_nettype none

module sgm_path_cost_aggregation_top #(
  parameter int MAX_DISPARITIES = sgmpa_pkg::MAX_DISPARITIES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [sgmpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [sgmpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  sgmpa_in_if.sink                                  cost_in,
  sgmpa_out_if.source                               result_out
);

  localparam int DW  = $clog2(MAX_DISPARITIES);
  localparam int NW  = $clog2(MAX_DISPARITIES + 1);
  localparam int XW  = (NW > sgmpa_pkg::DCOUNT_W) ? NW : sgmpa_pkg::DCOUNT_W;
  localparam int QW  = DW + $bits(sgmpa_pkg::q_entry_t);

  // Configuration registers
  logic [sgmpa_pkg::P1_W-1:0]      penalty_small;
  logic [sgmpa_pkg::P2_W-1:0]      penalty_large_base;
  logic [sgmpa_pkg::DCOUNT_W-1:0]  disparity_count;
  logic [XW-1:0]                   dcount_ext;
  logic [NW-1:0]                   active_count;

  // Front to queue to back
  logic                            q_push;
  logic [DW-1:0]                   push_d;
  sgmpa_pkg::q_entry_t             push_entry;
  logic                            q_pop;
  logic [QW-1:0]                   q_head;
  sgmpa_pkg::q_status_t            q_status;
  logic [DW-1:0]                   head_d;
  sgmpa_pkg::q_entry_t             head_entry;

  // Unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_small      <= sgmpa_pkg::RST_PENALTY_SMALL;
      penalty_large_base <= sgmpa_pkg::RST_PENALTY_LARGE_BASE;
      disparity_count    <= sgmpa_pkg::RST_DISPARITY_COUNT;
    end else if (cfg_we) begin
      case (sgmpa_pkg::cfg_index_t'(cfg_index))
        sgmpa_pkg::CFG_PENALTY_SMALL: begin
          penalty_small <= cfg_data[sgmpa_pkg::P1_W-1:0];
        end
        sgmpa_pkg::CFG_PENALTY_LARGE_BASE: begin
          penalty_large_base <= cfg_data[sgmpa_pkg::P2_W-1:0];
        end
        sgmpa_pkg::CFG_DISPARITY_COUNT: begin
          disparity_count <= cfg_data[sgmpa_pkg::DCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp the count in use to 1..MAX_DISPARITIES
  always_comb begin
    dcount_ext = XW'(disparity_count);
    if (dcount_ext == '0) begin
      active_count = NW'(1);
    end else if (dcount_ext > XW'(MAX_DISPARITIES)) begin
      active_count = NW'(MAX_DISPARITIES);
    end else begin
      active_count = NW'(dcount_ext);
    end
  end

  sgmpa_front #(
    .MAX_DISPARITIES (MAX_DISPARITIES)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .cost_in            (cost_in),
    .penalty_large_base (penalty_large_base),
    .active_count       (active_count),
    .q_status           (q_status),
    .push               (q_push),
    .push_d             (push_d),
    .push_entry         (push_entry)
  );

  sgmpa_queue #(
    .WIDTH (QW),
    .DEPTH (sgmpa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_d, push_entry}),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  assign head_d     = q_head[QW-1 -: DW];
  assign head_entry = q_head[$bits(sgmpa_pkg::q_entry_t)-1:0];

  sgmpa_back #(
    .MAX_DISPARITIES (MAX_DISPARITIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .penalty_small (penalty_small),
    .q_status      (q_status),
    .head_d        (head_d),
    .head_entry    (head_entry),
    .pop           (q_pop),
    .result_out    (result_out)
  );

  // The front never pushes into a full queue and the back never pops an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

  // Input ready is raised only when an element can be placed in the queue
  a_ready_has_room: assert property (@(posedge clk) disable iff (rst)
    cost_in.ready |-> !q_status.full)
    else $error("input ready while queue full");

endmodule

`default_nettype wire

// ===== tb/sgm_path_cost_aggregation_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sgm_path_cost_aggregation_top: directed and random cost streams.
// Depends on sgmpa_pkg, the sgmpa_ifs stream interfaces and the block's RTL.

module sgm_path_cost_aggregation_top_test;

  localparam int MAX_DISP       = 64;
  localparam int QUIET_LIMIT    = 3000;  // cycles with no transfer on either channel
  localparam int HOLDOFF_CYCLES = 200;
  localparam int END_WAIT       = 20;
  localparam int REPORT_LIMIT   = 10;

  // One aggregated element as the block should deliver it
  typedef struct packed {
    logic [sgmpa_pkg::AGG_W-1:0]      cost;
    logic [sgmpa_pkg::DISP_IDX_W-1:0] index;
    logic                             done;
  } lr_result_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [sgmpa_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sgmpa_pkg::CFG_DATA_W-1:0]  cfg_data;

  sgmpa_in_if  cost_in();
  sgmpa_out_if result_out();

  sgm_path_cost_aggregation_top #(
    .MAX_DISPARITIES(MAX_DISP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cost_in(cost_in),
    .result_out(result_out)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Path state of the aggregation, mirrored here so each transfer can be
  // predicted the moment it is accepted.
  // ---------------------------------------------------------------------------
  int unsigned p1_reg      = 10;
  int unsigned p2_base_reg = 150;
  int unsigned dcount_reg  = 64;

  int unsigned lr_mem [MAX_DISP];
  bit          lr_written [MAX_DISP];  // entries the RTL has really stored
  int unsigned left_l     = 0;
  bit          left_known = 1'b1;
  int unsigned min_prev   = 32767;
  int unsigned min_run    = 32767;
  int unsigned disp_ctr   = 0;
  int unsigned gray_prev  = 0;
  int unsigned p2_cur     = 0;

  lr_result_t lr_expected [$];

  // Stimulus shaping and bookkeeping
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int unsigned path_left   = 0;
  bit          path_first  = 1'b1;
  logic [7:0]  gray_now    = 8'd0;
  int unsigned elements_sent    = 0;
  int unsigned start_elements   = 0;
  int unsigned settings_written = 0;
  int unsigned results_checked  = 0;
  int unsigned pixels_done      = 0;
  int unsigned mismatches       = 0;

  // Receiver hold-off request: toggled by a test, counted down by the receiver
  bit holdoff_req  = 1'b0;
  bit holdoff_ack  = 1'b0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  // Zero acts as one, anything above the memory depth acts as the depth
  function automatic int unsigned active_disparities();
    if (dcount_reg == 0) return 1;
    if (dcount_reg > MAX_DISP) return MAX_DISP;
    return dcount_reg;
  endfunction

  function automatic int unsigned current_offset();
    return (disp_ctr >= MAX_DISP) ? MAX_DISP - 1 : disp_ctr;
  endfunction

  // A non-start element may only read path cost entries that hold real data
  function automatic bit element_is_safe();
    int unsigned n;
    int unsigned d;
    n = active_disparities();
    d = current_offset();
    return lr_written[d] && (d + 1 >= n || lr_written[d + 1]) && (d == 0 || left_known);
  endfunction

  function automatic lr_result_t aggregate_element(
      logic [sgmpa_pkg::MATCH_COST_W-1:0] cost,
      logic [sgmpa_pkg::GRAY_W-1:0] gray, logic start);
    lr_result_t  r;
    int unsigned n;
    int unsigned d;
    int unsigned diff;
    int unsigned m;
    int unsigned sum;
    int unsigned res;
    bit          last;
    n    = active_disparities();
    d    = current_offset();
    last = (d + 1 >= n);
    // P2 follows the gray step between this pixel and the previous one
    if (d == 0) begin
      diff      = (gray >= gray_prev) ? gray - gray_prev : gray_prev - gray;
      p2_cur    = (p2_base_reg / (diff + 1)) & 10'h3FF;
      gray_prev = gray;
    end
    if (start) begin
      res = cost;
    end else begin
      m = lr_mem[d];
      if (d > 0 && left_l + p1_reg < m) m = left_l + p1_reg;
      if (d + 1 < n && lr_mem[d + 1] + p1_reg < m) m = lr_mem[d + 1] + p1_reg;
      if (min_prev + p2_cur < m) m = min_prev + p2_cur;
      sum = cost + m;
      if (sum <= min_prev) res = 0;
      else if (sum - min_prev > 32767) res = 32767;
      else res = sum - min_prev;
    end
    left_l        = lr_mem[d];
    left_known    = lr_written[d];
    lr_mem[d]     = res;
    lr_written[d] = 1'b1;
    if (res < min_run) min_run = res;
    r.cost  = sgmpa_pkg::AGG_W'(res);
    r.index = sgmpa_pkg::DISP_IDX_W'(d);
    r.done  = last;
    if (last) begin
      min_prev = min_run;
      min_run  = 32767;
      disp_ctr = 0;
    end else begin
      disp_ctr = d + 1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Write all three registers; only called while nothing is in flight
  task automatic program_registers(int unsigned p1, int unsigned p2b, int unsigned count);
    cfg_we    <= 1'b1;
    cfg_index <= sgmpa_pkg::CFG_PENALTY_SMALL;
    cfg_data  <= sgmpa_pkg::CFG_DATA_W'(p1 & 8'hFF);
    @(posedge clk);
    cfg_index <= sgmpa_pkg::CFG_PENALTY_LARGE_BASE;
    cfg_data  <= sgmpa_pkg::CFG_DATA_W'(p2b & 10'h3FF);
    @(posedge clk);
    cfg_index <= sgmpa_pkg::CFG_DISPARITY_COUNT;
    cfg_data  <= sgmpa_pkg::CFG_DATA_W'(count & 7'h7F);
    @(posedge clk);
    cfg_we      <= 1'b0;
    p1_reg      = p1 & 8'hFF;
    p2_base_reg = p2b & 10'h3FF;
    dcount_reg  = count & 7'h7F;
    settings_written++;
    @(posedge clk);
  endtask

  // Offer one cost element, hold it until accepted, then record its prediction.
  // A start flag is forced where a plain element would read unwritten path costs.
  task automatic send_element(logic [sgmpa_pkg::MATCH_COST_W-1:0] cost,
                              logic [sgmpa_pkg::GRAY_W-1:0] gray, logic start);
    logic       st;
    lr_result_t predicted;
    st = start | !element_is_safe();
    while ($urandom_range(99) < tx_idle_pct) begin
      cost_in.valid <= 1'b0;
      @(posedge clk);
    end
    cost_in.valid      <= 1'b1;
    cost_in.match_cost <= cost;
    cost_in.gray       <= gray;
    cost_in.path_start <= st;
    @(posedge clk);
    while (!cost_in.ready) @(posedge clk);
    predicted   = aggregate_element(cost, gray, st);
    lr_expected = {lr_expected, predicted};
    elements_sent++;
    if (st) start_elements++;
  endtask

  // Stop offering and wait until every predicted result has been transferred
  task automatic wait_for_results();
    cost_in.valid <= 1'b0;
    while (lr_expected.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Well-formed paths with random content, a little start-flag noise on top
  task automatic run_random(int unsigned count);
    logic [sgmpa_pkg::MATCH_COST_W-1:0] cost;
    logic                               start;
    for (int unsigned i = 0; i < count; i++) begin
      if (disp_ctr == 0) begin
        path_first = (path_left == 0);
        if (path_first) path_left = $urandom_range(1, 10);
        path_left--;
        case ($urandom_range(9))
          0:       gray_now = 8'd0;
          1:       gray_now = 8'd255;
          2, 3, 4: gray_now = gray_now + 8'($urandom_range(0, 6)) - 8'd3;
          default: gray_now = 8'($urandom_range(0, 255));
        endcase
      end else if ($urandom_range(99) < 15) begin
        gray_now = 8'($urandom_range(0, 255));  // ignored past offset zero
      end
      start = path_first;
      if ($urandom_range(99) < 4) start = !start;
      case ($urandom_range(9))
        0:       cost = '0;
        1:       cost = 14'd16383;
        2, 3, 4: cost = 14'($urandom_range(0, 63));
        5:       cost = 14'($urandom_range(0, 1023));
        default: cost = 14'($urandom_range(0, 16383));
      endcase
      send_element(cost, gray_now, start);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Three pixels of three disparities: pass-through, the widest gray step, none
  task automatic test_directed_pixels();
    program_registers(255, 1023, 3);
    send_element(14'd16383, 8'd0, 1'b1);
    send_element(14'd0, 8'd0, 1'b1);
    send_element(14'd16383, 8'd0, 1'b1);
    send_element(14'd0, 8'd255, 1'b0);
    send_element(14'd16383, 8'd255, 1'b0);
    send_element(14'd1, 8'd255, 1'b0);
    send_element(14'd100, 8'd255, 1'b0);
    send_element(14'd0, 8'd255, 1'b0);
    send_element(14'd100, 8'd255, 1'b0);
    wait_for_results();
  endtask

  // Zero disparities acts as one: every element is a pixel of its own
  task automatic test_disparity_count_limits();
    program_registers(0, 0, 0);
    send_element(14'd5, 8'd128, 1'b1);
    send_element(14'd16383, 8'd0, 1'b0);
    send_element(14'd0, 8'd255, 1'b0);
    wait_for_results();
  endtask

  // Shrink the count so stale deeper entries sit below the previous minimum,
  // grow it again to drive the sum under zero, then change it mid-pixel
  task automatic test_saturation_and_count_change();
    program_registers(10, 150, 4);
    send_element(14'd900, 8'd40, 1'b1);
    send_element(14'd900, 8'd40, 1'b1);
    send_element(14'd0, 8'd40, 1'b1);
    send_element(14'd0, 8'd40, 1'b1);
    wait_for_results();
    program_registers(10, 150, 2);
    send_element(14'd500, 8'd40, 1'b1);
    send_element(14'd500, 8'd40, 1'b1);
    wait_for_results();
    program_registers(10, 150, 4);
    for (int i = 0; i < 4; i++) send_element(14'd0, 8'd41, 1'b0);
    // flag on only some elements, and a pixel cut short by a smaller count
    send_element(14'd7, 8'd90, 1'b1);
    send_element(14'd16383, 8'd90, 1'b0);
    wait_for_results();
    program_registers(10, 150, 2);
    send_element(14'd3, 8'd90, 1'b0);
    wait_for_results();
  endtask

  // Hold the receiver off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    program_registers(20, 300, 4);
    holdoff_req <= ~holdoff_req;
    run_random(40);
    wait_for_results();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct);
    int unsigned count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_results();
      case ($urandom_range(9))
        0:       count = 0;
        1:       count = 127;
        2:       count = 64;
        3:       count = 65;
        default: count = $urandom_range(1, 8);
      endcase
      if (phase == 0) program_registers(0, 0, 1);
      else if (phase == 1) program_registers(255, 1023, 127);
      else program_registers($urandom_range(0, 255), $urandom_range(0, 1023), count);
      run_random(65);
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack      <= holdoff_req;
      holdoff_left     <= HOLDOFF_CYCLES;
      result_out.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left     <= holdoff_left - 1;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  lr_result_t want;
  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      results_checked++;
      if (result_out.pixel_done) pixels_done++;
      if (lr_expected.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: cost %0d index %0d done %0d",
                   result_out.aggregated_cost, result_out.disparity_index,
                   result_out.pixel_done);
        mismatches++;
      end else begin
        want = lr_expected.pop_front();
        if (result_out.aggregated_cost !== want.cost ||
            result_out.disparity_index !== want.index ||
            result_out.pixel_done !== want.done) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: want cost %0d index %0d done %0d, got cost %0d index %0d done %0d",
                     want.cost, want.index, want.done, result_out.aggregated_cost,
                     result_out.disparity_index, result_out.pixel_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: drop the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (cost_in.valid && cost_in.ready) || (result_out.valid && result_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    cost_in.valid      = 1'b0;
    cost_in.match_cost = '0;
    cost_in.gray       = '0;
    cost_in.path_start = 1'b0;
    result_out.ready   = 1'b0;
    for (int i = 0; i < MAX_DISP; i++) begin
      lr_mem[i]     = 0;
      lr_written[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 22;
    rx_idle_pct = 79;
    test_directed_pixels();
    test_disparity_count_limits();
    test_saturation_and_count_change();
    test_backpressure();
    test_random_traffic(22, 79);
    test_random_traffic(79, 22);
    test_random_traffic(0, 0);

    // Drain, then leave room for any stray transfer to show up
    wait_for_results();
    repeat (END_WAIT) @(posedge clk);
    $display("run covered %0d cost elements (%0d flagged as path start) over %0d settings",
             elements_sent, start_elements, settings_written);
    $display("%0d results in %0d pixels checked, %0d mismatches, %0d outstanding",
             results_checked, pixels_done, mismatches, lr_expected.size());
    if (mismatches == 0 && lr_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sgmpa_pkg.sv
rtl/core/sgmpa_ifs.sv
rtl/core/sgmpa_ram.sv
rtl/core/sgmpa_div.sv
rtl/core/sgmpa_queue.sv
rtl/core/sgmpa_front.sv
rtl/core/sgmpa_back.sv
rtl/core/sgm_path_cost_aggregation_top.sv
tb/sgm_path_cost_aggregation_top_test.sv
